// ===== rtl/hff_pkg.sv =====
package hff_pkg;

    localparam int ELEM_W         = 16;
    localparam int FRAC_W         = 12;
    localparam int DAMP_W         = 16;
    localparam int RADIUS_W       = 15;
    localparam int CFG_W          = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int VALUE_BITS_DEF = 16;

    // Smoothed state: origin x,y,z, constant force x,y,z, gain row major, radius
    localparam int NUM_SM   = 16;
    localparam int SM_IDX_W = $clog2(NUM_SM);
    localparam logic [SM_IDX_W-1:0] SM_CONST_BASE = SM_IDX_W'(3);
    localparam logic [SM_IDX_W-1:0] SM_GAIN_BASE  = SM_IDX_W'(6);
    localparam logic [SM_IDX_W-1:0] SM_RADIUS     = SM_IDX_W'(15);

    localparam logic [DAMP_W-1:0] DAMP_RESET = DAMP_W'(58982);

    // Signed multiplier operands and product
    localparam int MUL_IN_W = ELEM_W + 1;
    localparam int MUL_W    = 2 * MUL_IN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN = 3'd0,
        REG_CONST  = 3'd1,
        REG_GAIN0  = 3'd2,
        REG_GAIN1  = 3'd3,
        REG_GAIN2  = 3'd4,
        REG_RADIUS = 3'd5,
        REG_DAMP   = 3'd6,
        REG_ENABLE = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_BLEND,
        OP_DIST,
        OP_RAD,
        OP_GAIN,
        OP_FIN
    } dp_op_t;

    typedef enum logic [1:0] {
        ST_INACTIVE = 2'd0,
        ST_OUTSIDE  = 2'd1,
        ST_APPLIED  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLEND,
        S_DIST,
        S_RAD,
        S_CHECK,
        S_GAIN,
        S_DRAIN,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t              op;
        logic [SM_IDX_W-1:0] idx;
        logic [1:0]          row;
        logic [1:0]          col;
        logic                load_out;
        status_t             res;
    } hff_cmd_t;

    typedef struct packed {
        logic enable;
        logic outside;
    } hff_stat_t;

endpackage

// ===== rtl/hff_ctrl.sv =====
module hff_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  hff_pkg::hff_stat_t  stat,
    output hff_pkg::hff_cmd_t   cmd
);
    import hff_pkg::*;

    localparam logic [SM_IDX_W-1:0] BLEND_LAST = SM_IDX_W'(NUM_SM - 1);
    localparam logic [SM_IDX_W-1:0] DIST_LAST  = SM_IDX_W'(2);
    // row 2, finishing slot
    localparam logic [SM_IDX_W-1:0] GAIN_LAST  = {2'd2, 2'd3};

    ctrl_state_t         state_reg, state_next;
    logic [SM_IDX_W-1:0] cnt_reg, cnt_next;
    status_t             res_reg, res_next;
    logic                out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            res_reg       <= ST_INACTIVE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.res      = res_reg;
        in_ready     = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op   = OP_CAPTURE;
                    cnt_next = '0;
                    if (stat.enable)
                    begin
                        state_next = S_BLEND;
                    end
                    else
                    begin
                        res_next   = ST_INACTIVE;
                        state_next = S_DONE;
                    end
                end
            end
            S_BLEND:
            begin
                cmd.op  = OP_BLEND;
                cmd.idx = cnt_reg;
                if (cnt_reg == BLEND_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DIST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIST:
            begin
                cmd.op  = OP_DIST;
                cmd.col = cnt_reg[1:0];
                if (cnt_reg == DIST_LAST)
                begin
                    state_next = S_RAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RAD:
            begin
                cmd.op     = OP_RAD;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // distance sum and squared radius have both settled here
                cnt_next = '0;
                if (stat.outside)
                begin
                    res_next   = ST_OUTSIDE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_GAIN;
                end
            end
            S_GAIN:
            begin
                cmd.row = cnt_reg[3:2];
                cmd.col = cnt_reg[1:0];
                cmd.op  = (cnt_reg[1:0] == 2'd3) ? OP_FIN : OP_GAIN;
                if (cnt_reg == GAIN_LAST)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                res_next   = ST_APPLIED;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_inactive_short: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !stat.enable) |=> (state_reg == S_DONE))
        else $error("inactive item did not go straight to result");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || out_ready)) |=> out_valid_reg)
        else $error("result not presented after load");
`endif

endmodule

// ===== rtl/hff_dp.sv =====
module hff_dp #(
    parameter int VALUE_BITS = hff_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hff_pkg::hff_cmd_t                   cmd,
    output hff_pkg::hff_stat_t                  stat,
    input  logic signed [hff_pkg::ELEM_W-1:0]   pos_x,
    input  logic signed [hff_pkg::ELEM_W-1:0]   pos_y,
    input  logic signed [hff_pkg::ELEM_W-1:0]   pos_z,
    input  logic                                restart,
    input  logic                                cfg_we,
    input  logic [hff_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hff_pkg::CFG_W-1:0]           cfg_wdata,
    output logic signed [hff_pkg::ELEM_W-1:0]   force_x,
    output logic signed [hff_pkg::ELEM_W-1:0]   force_y,
    output logic signed [hff_pkg::ELEM_W-1:0]   force_z,
    output logic [1:0]                          status
);
    import hff_pkg::*;

    localparam int TOT_W = MUL_W + 1;
    localparam logic signed [TOT_W-1:0] SAT_HI =
        TOT_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [TOT_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [TOT_W-1:0] BLEND_RND = TOT_W'(1) <<< (DAMP_W - 1);
    localparam logic signed [TOT_W-1:0] GAIN_RND  = TOT_W'(1) <<< (FRAC_W - 1);

    // configuration
    logic [CFG_W-1:0]    origin_reg;
    logic [CFG_W-1:0]    const_reg;
    logic [CFG_W-1:0]    gain_reg [3];
    logic [RADIUS_W-1:0] radius_reg;
    logic [DAMP_W-1:0]   damp_reg;
    logic                enable_reg;

    // smoothed state and working registers
    logic signed [ELEM_W-1:0]   sm_reg [NUM_SM];
    logic signed [ELEM_W-1:0]   pos_reg [3];
    logic signed [MUL_IN_W-1:0] off_reg [3];
    logic signed [ELEM_W-1:0]   fw_reg [3];
    logic signed [MUL_W-1:0]    prod_reg;
    logic signed [ELEM_W-1:0]   t_reg;
    logic signed [ELEM_W-1:0]   cst_reg;
    logic [TOT_W-1:0]           dist_reg;
    logic signed [TOT_W-1:0]    acc_reg;
    dp_op_t                     op_d_reg;
    logic [SM_IDX_W-1:0]        idx_d_reg;
    logic [1:0]                 row_d_reg;
    logic [1:0]                 col_d_reg;

    logic signed [ELEM_W-1:0]   force_x_reg, force_y_reg, force_z_reg;
    status_t                    status_reg;

    logic signed [ELEM_W-1:0]   tgt [NUM_SM];
    logic [SM_IDX_W-1:0]        rd_idx;
    logic signed [ELEM_W-1:0]   rd_s;
    logic signed [ELEM_W-1:0]   rd_t;
    logic signed [MUL_IN_W-1:0] off;
    logic signed [MUL_IN_W-1:0] mul_a, mul_b;
    logic signed [TOT_W-1:0]    prod_ext;
    logic signed [TOT_W-1:0]    blend_sum;
    logic signed [ELEM_W-1:0]   blend_new;
    logic signed [TOT_W-1:0]    rnd;
    logic signed [TOT_W-1:0]    tot;
    logic signed [TOT_W-1:0]    sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            const_reg  <= '0;
            gain_reg   <= '{default: '0};
            radius_reg <= '0;
            damp_reg   <= DAMP_RESET;
            enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN: origin_reg  <= cfg_wdata;
                REG_CONST:  const_reg   <= cfg_wdata;
                REG_GAIN0:  gain_reg[0] <= cfg_wdata;
                REG_GAIN1:  gain_reg[1] <= cfg_wdata;
                REG_GAIN2:  gain_reg[2] <= cfg_wdata;
                REG_RADIUS: radius_reg  <= cfg_wdata[RADIUS_W-1:0];
                REG_DAMP:   damp_reg    <= cfg_wdata[DAMP_W-1:0];
                REG_ENABLE: enable_reg  <= cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // blend targets, in the same order as the smoothed state
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            tgt[k]     = origin_reg[ELEM_W*k +: ELEM_W];
            tgt[3 + k] = const_reg[ELEM_W*k +: ELEM_W];
            for (int c = 0; c < 3; c++)
            begin
                tgt[6 + 3*k + c] = gain_reg[k][ELEM_W*c +: ELEM_W];
            end
        end
        tgt[NUM_SM-1] = {{(ELEM_W-RADIUS_W){1'b0}}, radius_reg};
    end

    always_comb
    begin
        case (cmd.op)
            OP_BLEND: rd_idx = cmd.idx;
            OP_DIST:  rd_idx = {2'b00, cmd.col};
            OP_RAD:   rd_idx = SM_RADIUS;
            OP_GAIN:  rd_idx = SM_GAIN_BASE + {1'b0, cmd.row, 1'b0}
                               + {2'b00, cmd.row} + {2'b00, cmd.col};
            OP_FIN:   rd_idx = SM_CONST_BASE + {2'b00, cmd.row};
            default:  rd_idx = '0;
        endcase
    end

    assign rd_s = sm_reg[rd_idx];
    assign rd_t = tgt[rd_idx];

    always_comb
    begin
        off   = '0;
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_BLEND:
            begin
                // d*s + (1-d)*t == t + d*(s - t)
                mul_a = {1'b0, damp_reg};
                mul_b = {rd_s[ELEM_W-1], rd_s} - {rd_t[ELEM_W-1], rd_t};
            end
            OP_DIST:
            begin
                off   = {pos_reg[cmd.col][ELEM_W-1], pos_reg[cmd.col]}
                        - {rd_s[ELEM_W-1], rd_s};
                mul_a = off;
                mul_b = off;
            end
            OP_RAD:
            begin
                mul_a = {rd_s[ELEM_W-1], rd_s};
                mul_b = {rd_s[ELEM_W-1], rd_s};
            end
            OP_GAIN:
            begin
                mul_a = {rd_s[ELEM_W-1], rd_s};
                mul_b = off_reg[cmd.col];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_d_reg <= OP_NONE;
        end
        else
        begin
            op_d_reg <= cmd.op;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        t_reg     <= rd_t;
        cst_reg   <= rd_s;
        idx_d_reg <= cmd.idx;
        row_d_reg <= cmd.row;
        col_d_reg <= cmd.col;
        if (cmd.op == OP_DIST)
        begin
            off_reg[cmd.col] <= off;
        end
        if (cmd.op == OP_CAPTURE)
        begin
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
        end
    end

    // accumulate stage
    assign prod_ext  = {prod_reg[MUL_W-1], prod_reg};
    assign blend_sum = {{(TOT_W-ELEM_W-DAMP_W){t_reg[ELEM_W-1]}}, t_reg, {DAMP_W{1'b0}}}
                       + prod_ext + BLEND_RND;
    assign blend_new = blend_sum[DAMP_W +: ELEM_W];

    assign rnd = (acc_reg + GAIN_RND) >>> FRAC_W;
    assign tot = rnd + {{(TOT_W-ELEM_W){cst_reg[ELEM_W-1]}}, cst_reg};

    always_comb
    begin
        if (tot > SAT_HI)
        begin
            sat = SAT_HI;
        end
        else if (tot < SAT_LO)
        begin
            sat = SAT_LO;
        end
        else
        begin
            sat = tot;
        end
    end

    always_ff @(posedge clk)
    begin
        case (op_d_reg)
            OP_DIST:
            begin
                dist_reg <= ((col_d_reg == 2'd0) ? '0 : dist_reg) + {1'b0, prod_reg};
            end
            OP_GAIN:
            begin
                acc_reg <= ((col_d_reg == 2'd0) ? '0 : acc_reg) + prod_ext;
            end
            OP_FIN:
            begin
                fw_reg[row_d_reg] <= sat[ELEM_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_reg <= '{default: '0};
        end
        else if (cmd.op == OP_CAPTURE && restart)
        begin
            sm_reg[SM_RADIUS] <= '0;
        end
        else if (op_d_reg == OP_BLEND)
        begin
            sm_reg[idx_d_reg] <= blend_new;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg <= cmd.res;
            if (cmd.res == ST_APPLIED)
            begin
                force_x_reg <= fw_reg[0];
                force_y_reg <= fw_reg[1];
                force_z_reg <= fw_reg[2];
            end
            else
            begin
                force_x_reg <= '0;
                force_y_reg <= '0;
                force_z_reg <= '0;
            end
        end
    end

    // valid in the check cycle: product register then holds the squared radius
    assign stat.outside = (dist_reg > {1'b0, prod_reg});
    assign stat.enable  = enable_reg;

    assign force_x = force_x_reg;
    assign force_y = force_y_reg;
    assign force_z = force_z_reg;
    assign status  = status_reg;

`ifndef SYNTH
    a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && cmd.res != ST_APPLIED)
        |=> (force_x_reg == '0 && force_y_reg == '0 && force_z_reg == '0))
        else $error("nonzero force without applied status");
`endif

endmodule

// ===== rtl/haptic_force_field_effect_unit.sv =====
// Haptic force-field effect: takes one effector position per transfer and returns one
// force vector with a status code (inactive, outside cutoff radius, applied). While enabled,
// every item first moves the smoothed origin, constant force, gain matrix and radius one
// damping step toward the configured targets, then tests the squared offset length against
// the squared radius and, inside it, forms constant + gain * offset, saturated. One item
// is worked at a time. The single shared 17x17 multiplier does the 16 blends, 4 squares and
// 9 gain products one per cycle; an item outside the radius skips the gain products, and a
// disabled item goes straight to the result. A finished result sits in the output register
// while the next position is taken. The user must write the configuration registers through
// cfg_we/cfg_index/cfg_wdata only while idle; the block itself does not enforce this.
module haptic_force_field_effect_unit #(
    parameter int VALUE_BITS = hff_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [hff_pkg::ELEM_W-1:0]   pos_x,
    input  logic signed [hff_pkg::ELEM_W-1:0]   pos_y,
    input  logic signed [hff_pkg::ELEM_W-1:0]   pos_z,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hff_pkg::ELEM_W-1:0]   force_x,
    output logic signed [hff_pkg::ELEM_W-1:0]   force_y,
    output logic signed [hff_pkg::ELEM_W-1:0]   force_z,
    output logic [1:0]                          status,
    input  logic                                cfg_we,
    input  logic [hff_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hff_pkg::CFG_W-1:0]           cfg_wdata
);
    import hff_pkg::*;

    hff_cmd_t  cmd;
    hff_stat_t stat;

    hff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hff_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .restart   (restart),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .force_x   (force_x),
        .force_y   (force_y),
        .force_z   (force_z),
        .status    (status)
    );

endmodule
